@@ rtl/core/dpve_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpve_pkg: shared types for the delta point varint encoder
// Beat payloads, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package dpve_pkg;

  localparam int unsigned PosW   = 48;
  localparam int unsigned RawW   = 64;
  localparam int unsigned ScaleW = 32;

  localparam logic [31:0] ScaleReset = 32'h0001_0000;
  localparam logic [6:0]  PayloadMask = 7'h7f;
  localparam logic [7:0]  MoreFlag = 8'h80;

  typedef struct packed {
    logic                   func;
    logic signed [PosW-1:0] position;
    logic signed [PosW-1:0] last_position;
    logic [RawW-1:0]        raw_value;
  } in_data_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_data_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam logic FuncDelta = 1'b0;
  localparam logic FuncRaw   = 1'b1;

  typedef struct packed {
    logic load;
    logic sub;
    logic abs;
    logic mul_lo;
    logic mul_hi;
    logic add;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_func;
    logic more;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/core/dpve_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpve_ctrl: encoder sequencer
// Delta item: subtract, magnitude, two multiplies, add, emit. Raw item: emit.
// ----------------------------------------------------------------------------
module dpve_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dpve_pkg::dp_sts_t sts,
  output dpve_pkg::dp_cmd_t cmd
);
  import dpve_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (sts.in_func == FuncRaw) ? ST_EMIT : ST_SUB;
        end
      end
      ST_SUB:    state_nxt = ST_ABS;
      ST_ABS:    state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free && !sts.more) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SUB:    cmd.sub = 1'b1;
      ST_ABS:    cmd.abs = 1'b1;
      ST_MUL_LO: cmd.mul_lo = 1'b1;
      ST_MUL_HI: cmd.mul_hi = 1'b1;
      ST_ADD:    cmd.add = 1'b1;
      ST_EMIT:   cmd.emit = sts.out_free;
      default:   in_stall = 1'b1;
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted an item while busy");

  a_delta_path: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.in_func == FuncDelta) |=> (state_r == ST_SUB))
    else $error("delta item skipped subtract");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && sts.out_free && !sts.more) |=> (state_r == ST_IDLE))
    else $error("run did not end after last beat");
`endif

endmodule

@@ rtl/core/dpve_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpve_dpath: encoder datapath
// Scale register, residual and scaled magnitude, code word shifter, output reg.
// ----------------------------------------------------------------------------
module dpve_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  dpve_pkg::in_data_t  in_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output dpve_pkg::out_data_t out_data,
  input  dpve_pkg::dp_cmd_t   cmd,
  output dpve_pkg::dp_sts_t   sts
);
  import dpve_pkg::*;

  logic [ScaleW-1:0]  scale_r;
  logic [PosW-1:0]    pos_r;
  logic [PosW-1:0]    last_r;
  logic [PosW:0]      diff_r;
  logic               neg_r;
  logic [PosW-1:0]    mag_r;
  logic [31:0]        lohi_r;
  logic [PosW-1:0]    hiprod_r;
  logic [RawW-1:0]    word_r;
  logic               out_valid_r;
  out_data_t          out_data_r;

  logic               more;
  logic [63:0]        lo_prod;
  logic [PosW-1:0]    hi_prod;
  logic [PosW:0]      diff_neg;
  logic [PosW-1:0]    ipart;

  assign more     = |word_r[RawW-1:7];
  assign lo_prod  = {32'b0, mag_r[31:0]} * {32'b0, scale_r};
  assign hi_prod  = {32'b0, mag_r[PosW-1:32]} * {16'b0, scale_r};
  assign diff_neg = (PosW+1)'(0) - diff_r;
  assign ipart    = hiprod_r + {16'b0, lohi_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= ScaleReset;
    end else if (cfg_we) begin
      scale_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r  <= in_data.position;
      last_r <= in_data.last_position;
      word_r <= in_data.raw_value;
    end else if (cmd.add) begin
      word_r <= {15'b0, ipart, neg_r};
    end else if (cmd.emit) begin
      word_r <= word_r >> 7;
    end
    if (cmd.sub) begin
      diff_r <= {pos_r[PosW-1], pos_r} - {last_r[PosW-1], last_r};
    end
    if (cmd.abs) begin
      neg_r <= diff_r[PosW];
      mag_r <= diff_r[PosW] ? diff_neg[PosW-1:0] : diff_r[PosW-1:0];
    end
    if (cmd.mul_lo) begin
      lohi_r <= lo_prod[63:32];
    end
    if (cmd.mul_hi) begin
      hiprod_r <= hi_prod;
    end
  end

  // output register: one beat per emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.out_byte  <= (more ? MoreFlag : 8'h00) | {1'b0, word_r[6:0] & PayloadMask};
      out_data_r.last_byte <= !more;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.in_func  = in_data.func;
  assign sts.more     = more;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

@@ rtl/core/delta_point_varint_encoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_point_varint_encoder_unit: delta / raw LEB128 varint encoder
// Raw items go straight to emit; delta items step through the datapath first.
// Throughput: one item at a time, 1 to 10 output beats per item, one per cycle
//   unless the output stalls; the input stays stalled until the last beat is sent;
//   delta uses one 32x32 then one 16x32 multiply step.
// Reset: synchronous active-low rst_n, scale returns to 0x0001_0000 (unsigned Q0.32).
// ----------------------------------------------------------------------------
module delta_point_varint_encoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dpve_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dpve_pkg::out_data_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import dpve_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  dpve_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpve_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ test/varint_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_stream_checker: scoreboard for the delta point varint encoder
// Tracks the scale register from config writes, expands every accepted input
// beat into its LEB128 byte run, and compares each accepted output beat,
// field by field, against the oldest byte still owed.
// ----------------------------------------------------------------------------
module varint_stream_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  dpve_pkg::in_data_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  dpve_pkg::out_data_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending,
  output int                  bytes_checked
);
  import dpve_pkg::*;

  logic [ScaleW-1:0] scale_q = ScaleReset;
  out_data_t         owed_bytes[$];
  int                err_cnt = 0;
  int                byte_cnt = 0;

  // Code word: raw value, or (|pos - last| * scale truncated) << 1 | sign.
  function automatic logic [63:0] varint_word(input in_data_t d, input logic [ScaleW-1:0] sc);
    logic signed [PosW:0]    residual;
    logic [PosW:0]           magnitude;
    logic [PosW+ScaleW:0]    product;
    if (d.func == FuncRaw) return d.raw_value;
    residual  = $signed({d.position[PosW-1], d.position})
              - $signed({d.last_position[PosW-1], d.last_position});
    magnitude = residual[PosW] ? -residual : residual;
    product   = magnitude * sc;
    return 64'({product[PosW+ScaleW-1:ScaleW], residual[PosW]});
  endfunction

  always @(posedge clk) begin : watch
    logic [63:0] word;
    out_data_t   b;
    out_data_t   want;
    if (!rst_n) begin
      scale_q = ScaleReset;
    end else begin
      if (cfg_valid && cfg_ready) scale_q = cfg_data;
      if (in_valid && !in_stall) begin
        word = varint_word(in_data, scale_q);
        do begin
          b.out_byte = {1'b0, word[6:0] & PayloadMask};
          word = word >> 7;
          if (word != 0) b.out_byte = b.out_byte | MoreFlag;
          b.last_byte = (word == 0);
          owed_bytes.push_back(b);
        end while (word != 0);
      end
      if (out_valid && !out_stall) begin
        if (owed_bytes.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected beat byte=%h last=%0b",
                     $time, out_data.out_byte, out_data.last_byte);
        end else begin
          want = owed_bytes.pop_front();
          byte_cnt++;
          if (out_data.out_byte !== want.out_byte || out_data.last_byte !== want.last_byte) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: beat mismatch exp byte=%h last=%0b got byte=%h last=%0b",
                       $time, want.out_byte, want.last_byte,
                       out_data.out_byte, out_data.last_byte);
          end
        end
      end
    end
    errors        <= err_cnt;
    pending       <= owed_bytes.size();
    bytes_checked <= byte_cnt;
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: delta point varint encoder top-level test
// Drives directed edge cases and random raw/delta beats across several scale
// settings and idle/stall mixes, including a long output hold-off that backs
// up the input; the varint_stream_checker scores every output beat.
// ----------------------------------------------------------------------------
module testbench;
  import dpve_pkg::*;

  localparam int HoldCycles = 300;
  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_data_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_data_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  int errors, pending, bytes_checked;
  int in_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off_req = 1'b0;
  int raw_items = 0;
  int delta_items = 0;
  int scale_settings = 1;

  delta_point_varint_encoder_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  varint_stream_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .bytes_checked(bytes_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Output side: random stalls, plus a long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (int k = 0; k < HoldCycles; k++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_data_t mk_item(input logic f, input logic [PosW-1:0] pos,
                                       input logic [PosW-1:0] last, input logic [RawW-1:0] raw);
    in_data_t d;
    d.func          = f;
    d.position      = pos;
    d.last_position = last;
    d.raw_value     = raw;
    return d;
  endfunction

  function automatic in_data_t rand_item();
    in_data_t               d;
    logic signed [63:0]     offset;
    d.func          = 1'($urandom_range(1));
    d.raw_value     = {$urandom, $urandom} >> $urandom_range(63);
    d.last_position = PosW'({$urandom, $urandom});
    offset          = $signed({$urandom, $urandom}) >>> $urandom_range(63);
    case ($urandom_range(7))
      0, 1:    d.position = PosW'({$urandom, $urandom});
      2:       d.position = $urandom_range(1) ? PosMax : PosMin;
      3: begin
        d.position      = $urandom_range(1) ? PosMax : PosMin;
        d.last_position = $urandom_range(1) ? PosMax : PosMin;
      end
      4:       d.position = d.last_position;
      default: d.position = d.last_position + offset[PosW-1:0];
    endcase
    return d;
  endfunction

  task automatic send_item(input in_data_t d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    if (d.func == FuncRaw) raw_items++;
    else delta_items++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_item(rand_item());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_scale(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_settings++;
  endtask

  initial begin
    in_data_t directed[$];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // raw run lengths, byte boundaries, bit patterns
    directed.push_back(mk_item(FuncRaw, '0, '0, 64'd0));
    directed.push_back(mk_item(FuncRaw, '0, '0, 64'd1));
    directed.push_back(mk_item(FuncRaw, '0, '0, 64'd127));
    directed.push_back(mk_item(FuncRaw, '0, '0, 64'd128));
    directed.push_back(mk_item(FuncRaw, '0, '0, 64'd16383));
    directed.push_back(mk_item(FuncRaw, '0, '0, 64'd16384));
    directed.push_back(mk_item(FuncRaw, '0, '0, 64'h8000_0000_0000_0000));
    directed.push_back(mk_item(FuncRaw, '0, '0, '1));
    directed.push_back(mk_item(FuncRaw, '0, '0, 64'h5555_5555_5555_5555));
    directed.push_back(mk_item(FuncRaw, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA));
    // positions ignored in raw mode
    directed.push_back(mk_item(FuncRaw, '1, PosMin, 64'd300));
    // delta: zero, fractions that truncate, unit steps
    directed.push_back(mk_item(FuncDelta, '0, '0, '1));
    directed.push_back(mk_item(FuncDelta, '0, 48'd1, '0));
    directed.push_back(mk_item(FuncDelta, 48'd1, '0, '0));
    directed.push_back(mk_item(FuncDelta, '1, '0, '0));
    directed.push_back(mk_item(FuncDelta, 48'd65536, '0, '0));
    directed.push_back(mk_item(FuncDelta, '0, 48'd65536, '0));
    // delta extremes
    directed.push_back(mk_item(FuncDelta, PosMax, PosMin, '0));
    directed.push_back(mk_item(FuncDelta, PosMin, PosMax, '0));
    directed.push_back(mk_item(FuncDelta, PosMax, PosMax, '0));
    directed.push_back(mk_item(FuncDelta, PosMin, PosMin, '0));
    directed.push_back(mk_item(FuncDelta, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, '1));
    directed.push_back(mk_item(FuncDelta, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, '1));

    foreach (directed[i]) send_item(directed[i]);
    run_random(30);
    drain();

    write_scale(32'h0000_0001);
    in_idle_pct = 51;
    run_random(45);
    drain();

    write_scale(32'hFFFF_FFFF);
    in_idle_pct = 0;
    stall_pct = 51;
    foreach (directed[i]) if (directed[i].func == FuncDelta) send_item(directed[i]);
    run_random(45);
    drain();

    write_scale($urandom | 32'd1);
    in_idle_pct = 11;
    stall_pct = 11;
    run_random(45);
    drain();

    // long receiver hold-off with the sender pushing back to back
    write_scale(32'h0000_8000);
    in_idle_pct = 0;
    stall_pct = 0;
    hold_off_req = 1'b1;
    run_random(35);
    drain();

    write_scale(ScaleReset);
    in_idle_pct = 11;
    stall_pct = 51;
    run_random(45);
    drain();

    repeat (20) @(posedge clk);
    $display("Sent %0d raw and %0d delta items over %0d scale settings,",
             raw_items, delta_items, scale_settings);
    $display("checked %0d output beats under mixed idle, stall and hold-off.", bytes_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
